>>> src/mds_pkg.sv
`default_nettype none

package mds_pkg;

    typedef logic [1:0]  t_cmd;
    typedef logic [1:0]  t_status;
    typedef logic [19:0] t_ppm;
    typedef logic [30:0] t_qty;
    typedef logic [62:0] t_time;
    typedef logic [61:0] t_fee;

    localparam t_cmd CMD_BEGIN = 2'd0;
    localparam t_cmd CMD_LEVEL = 2'd1;
    localparam t_cmd CMD_END   = 2'd2;

    localparam t_status ST_REJECTED = 2'd0;
    localparam t_status ST_FILLED   = 2'd1;
    localparam t_status ST_CANCELED = 2'd2;

    localparam logic REC_FILL   = 1'b0;
    localparam logic REC_STATUS = 1'b1;
    localparam logic KIND_LIMIT = 1'b1;

    // fee = floor((notional * rate + half) / denom)
    localparam t_ppm PPM_DENOM  = 20'd1000000;
    localparam t_ppm HALF_DENOM = 20'd500000;

    localparam int QTY_W     = 31;
    localparam int PROD_W    = 2 * QTY_W;
    localparam int ACC_W     = 82;
    localparam int DIV_RADIX = 4;
    localparam int DIV_W     = ((ACC_W + DIV_RADIX - 1) / DIV_RADIX) * DIV_RADIX;
    localparam int DIV_STEPS = DIV_W / DIV_RADIX;
    localparam int DIV_CNT_W = $clog2(DIV_STEPS);

endpackage

`default_nettype wire

>>> src/market_order_depth_sweep.sv
`default_nettype none

// Channel   Direction  Handshake               Payload
// request   in         i_in_valid / o_in_stall i_command .. i_level_quantity
// record    out        o_out_valid/i_out_stall o_record_kind .. o_left_quantity
// config    in         i_cfg_we                i_cfg_wdata (fee_rate_ppm)
//
// One request at a time. A level that fills passes through the shared 31x31
// multiplier (price*qty, then notional*rate in two halves) and then through
// the radix-16 divider by one million.
// Active order end and limit reject go to the emit state; others stay idle.
// Synchronous active-low reset clears all order state and the fee rate.
// A new request may be taken while the last record still waits on i_out_stall;
// the block then holds the next record until the output register frees up.
module market_order_depth_sweep import mds_pkg::*; (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    // request channel
    input  wire logic        i_in_valid,
    output logic             o_in_stall,
    input  wire t_cmd        i_command,
    input  wire logic [31:0] i_order_id,
    input  wire logic        i_order_side,
    input  wire logic        i_order_kind,
    input  wire t_qty        i_order_quantity,
    input  wire t_time       i_arrival_time,
    input  wire t_qty        i_level_price,
    input  wire t_qty        i_level_quantity,
    // record channel
    output logic             o_out_valid,
    input  wire logic        i_out_stall,
    output logic             o_record_kind,
    output logic [31:0]      o_out_order_id,
    output logic             o_out_side,
    output t_qty             o_fill_price,
    output t_qty             o_fill_quantity,
    output t_time            o_fill_time,
    output t_time            o_fill_sequence,
    output t_fee             o_fee_amount,
    output t_status          o_final_status,
    output t_qty             o_left_quantity,
    // fee rate register
    input  wire logic        i_cfg_we,
    input  wire t_ppm        i_cfg_wdata
);

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_M0   = 3'd1;  // price * qty
    localparam logic [2:0] S_M1   = 3'd2;  // low half of notional * rate
    localparam logic [2:0] S_M2   = 3'd3;  // high half of notional * rate
    localparam logic [2:0] S_M3   = 3'd4;  // sum and start divider
    localparam logic [2:0] S_DIV  = 3'd5;
    localparam logic [2:0] S_EMIT = 3'd6;

    logic [2:0]  r_state;
    t_ppm        r_rate;

    // order state
    logic        r_active;
    logic [31:0] r_held_id;
    logic        r_held_side;
    t_time       r_held_arrival;
    t_qty        r_remaining;
    logic        r_any_filled;
    t_time       r_seq;

    // pending record
    logic        r_pkind;
    logic [31:0] r_pid;
    logic        r_pside;
    t_status     r_pstat;
    t_qty        r_pleft;
    t_qty        r_price;
    t_qty        r_fq;

    // fee datapath
    t_qty        r_nhi;
    logic [ACC_W-1:0] r_acc;
    t_qty        mul_a;
    t_qty        mul_b;
    logic [PROD_W-1:0] prod;
    logic        div_start;
    logic        div_done;
    t_fee        div_q;
    logic [ACC_W-1:0] div_dvd;

    // output register
    logic        r_ov;
    logic        r_okind;
    logic [31:0] r_oid;
    logic        r_oside;
    t_qty        r_oprice;
    t_qty        r_oqty;
    t_time       r_otime;
    t_time       r_oseq;
    t_fee        r_ofee;
    t_status     r_ostat;
    t_qty        r_oleft;

    logic        acc_in;
    logic        slot_free;
    logic        emit;
    logic        is_fill;
    t_qty        fq;

    assign acc_in    = i_in_valid && (r_state == S_IDLE);
    assign slot_free = !r_ov || !i_out_stall;
    assign emit      = (r_state == S_EMIT) && slot_free;
    assign is_fill   = (r_pkind == REC_FILL);
    assign fq        = (r_remaining < i_level_quantity) ? r_remaining : i_level_quantity;

    // operand select for the shared multiplier
    always_comb begin
        unique case (r_state)
            S_M1: begin
                mul_a = prod[QTY_W-1:0];
                mul_b = QTY_W'(r_rate);
            end
            S_M2: begin
                mul_a = r_nhi;
                mul_b = QTY_W'(r_rate);
            end
            default: begin
                mul_a = r_price;
                mul_b = r_fq;
            end
        endcase
    end

    mds_mul u_mul (
        .i_clk (i_clk),
        .i_a   (mul_a),
        .i_b   (mul_b),
        .o_p   (prod)
    );

    // notional*rate = lo + (hi << 31); half denominator folded in for rounding
    assign div_start = (r_state == S_M3);
    assign div_dvd   = r_acc + {prod[50:0], 31'b0};

    mds_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (div_start),
        .i_dividend (div_dvd),
        .o_done     (div_done),
        .o_quotient (div_q)
    );

    always_ff @(posedge i_clk) begin
        if (r_state == S_M1) begin
            r_nhi <= prod[PROD_W-1:QTY_W];
        end
        if (r_state == S_M2) begin
            r_acc <= ACC_W'(prod[50:0]) + ACC_W'(HALF_DENOM);
        end
    end

    // sequencer and order state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state        <= S_IDLE;
            r_rate         <= '0;
            r_active       <= 1'b0;
            r_held_id      <= '0;
            r_held_side    <= 1'b0;
            r_held_arrival <= '0;
            r_remaining    <= '0;
            r_any_filled   <= 1'b0;
            r_seq          <= '0;
        end else begin
            if (i_cfg_we) begin
                r_rate <= (i_cfg_wdata > PPM_DENOM) ? PPM_DENOM : i_cfg_wdata;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (acc_in) begin
                        unique case (i_command)
                            CMD_BEGIN: begin
                                if (i_order_kind == KIND_LIMIT) begin
                                    r_active <= 1'b0;
                                    r_state  <= S_EMIT;
                                end else begin
                                    r_active       <= 1'b1;
                                    r_held_id      <= i_order_id;
                                    r_held_side    <= i_order_side;
                                    r_held_arrival <= i_arrival_time;
                                    r_remaining    <= i_order_quantity;
                                    r_any_filled   <= 1'b0;
                                end
                            end
                            CMD_LEVEL: begin
                                if (r_active && i_level_quantity != '0
                                        && r_remaining != '0) begin
                                    r_remaining  <= r_remaining - fq;
                                    r_any_filled <= 1'b1;
                                    r_state      <= S_M0;
                                end
                            end
                            CMD_END: begin
                                if (r_active) begin
                                    r_active <= 1'b0;
                                    r_state  <= S_EMIT;
                                end
                            end
                            default: ;
                        endcase
                    end
                end
                S_M0:  r_state <= S_M1;
                S_M1:  r_state <= S_M2;
                S_M2:  r_state <= S_M3;
                S_M3:  r_state <= S_DIV;
                S_DIV: begin
                    if (div_done) begin
                        r_state <= S_EMIT;
                    end
                end
                S_EMIT: begin
                    if (slot_free) begin
                        r_state <= S_IDLE;
                        if (is_fill) begin
                            r_seq <= r_seq + 1'b1;
                        end
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    // pending record payload
    always_ff @(posedge i_clk) begin
        if (acc_in) begin
            unique case (i_command)
                CMD_BEGIN: begin
                    r_pkind <= REC_STATUS;
                    r_pid   <= i_order_id;
                    r_pside <= i_order_side;
                    r_pstat <= ST_REJECTED;
                    r_pleft <= i_order_quantity;
                end
                CMD_LEVEL: begin
                    r_pkind <= REC_FILL;
                    r_pid   <= r_held_id;
                    r_pside <= r_held_side;
                    r_price <= i_level_price;
                    r_fq    <= fq;
                end
                CMD_END: begin
                    r_pkind <= REC_STATUS;
                    r_pid   <= r_held_id;
                    r_pside <= r_held_side;
                    r_pleft <= r_remaining;
                    if (!r_any_filled) begin
                        r_pstat <= ST_REJECTED;
                    end else if (r_remaining == '0) begin
                        r_pstat <= ST_FILLED;
                    end else begin
                        r_pstat <= ST_CANCELED;
                    end
                end
                default: ;
            endcase
        end
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ov <= 1'b0;
        end else if (emit) begin
            r_ov <= 1'b1;
        end else if (!i_out_stall) begin
            r_ov <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (emit) begin
            r_okind  <= r_pkind;
            r_oid    <= r_pid;
            r_oside  <= r_pside;
            r_oprice <= is_fill ? r_price : '0;
            r_oqty   <= is_fill ? r_fq : '0;
            r_otime  <= is_fill ? r_held_arrival : '0;
            r_oseq   <= is_fill ? r_seq : '0;
            r_ofee   <= is_fill ? div_q : '0;
            r_ostat  <= is_fill ? ST_REJECTED : r_pstat;
            r_oleft  <= is_fill ? '0 : r_pleft;
        end
    end

    assign o_in_stall      = (r_state != S_IDLE);
    assign o_out_valid     = r_ov;
    assign o_record_kind   = r_okind;
    assign o_out_order_id  = r_oid;
    assign o_out_side      = r_oside;
    assign o_fill_price    = r_oprice;
    assign o_fill_quantity = r_oqty;
    assign o_fill_time     = r_otime;
    assign o_fill_sequence = r_oseq;
    assign o_fee_amount    = r_ofee;
    assign o_final_status  = r_ostat;
    assign o_left_quantity = r_oleft;

endmodule

`default_nettype wire

>>> src/mds_mul.sv
`default_nettype none

// Shared 31x31 multiplier, product registered.
module mds_mul import mds_pkg::*; (
    input  wire logic              i_clk,
    input  wire logic [QTY_W-1:0]  i_a,
    input  wire logic [QTY_W-1:0]  i_b,
    output logic      [PROD_W-1:0] o_p
);

    logic [PROD_W-1:0] r_p;

    always_ff @(posedge i_clk) begin
        r_p <= PROD_W'(i_a) * PROD_W'(i_b);
    end

    assign o_p = r_p;

endmodule

`default_nettype wire

>>> src/mds_div.sv
`default_nettype none

// Division by the ppm denominator, radix-16 restoring.
module mds_div import mds_pkg::*; (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_start,
    input  wire logic [ACC_W-1:0] i_dividend,
    output logic                  o_done,
    output t_fee                  o_quotient
);

    logic                 r_busy;
    logic                 r_done;
    logic [DIV_CNT_W-1:0] r_cnt;
    logic [DIV_W-1:0]     r_shift;
    t_ppm                 r_rem;
    logic [DIV_W-1:0]     n_shift;
    t_ppm                 n_rem;

    always_comb begin
        logic [20:0] t;
        logic        q;
        n_shift = r_shift;
        n_rem   = r_rem;
        for (int i = 0; i < DIV_RADIX; i++) begin
            t       = {n_rem, n_shift[DIV_W-1]};
            q       = (t >= {1'b0, PPM_DENOM});
            n_rem   = q ? 20'(t - {1'b0, PPM_DENOM}) : t[19:0];
            n_shift = {n_shift[DIV_W-2:0], q};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= DIV_CNT_W'(DIV_STEPS - 1);
            end else if (r_busy) begin
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == '0) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_shift <= DIV_W'(i_dividend);
            r_rem   <= '0;
        end else if (r_busy) begin
            r_shift <= n_shift;
            r_rem   <= n_rem;
        end
    end

    assign o_done     = r_done;
    assign o_quotient = r_shift[61:0];

endmodule

`default_nettype wire
